// File: rtl/tsr_pkg.sv
// shared types for the tcp segment reassembly core
package tsr_pkg;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_REL   = 8'b0000_0010,
      S_POS   = 8'b0000_0100,
      S_OFF   = 8'b0000_1000,
      S_STORE = 8'b0001_0000,
      S_READ  = 8'b0010_0000,
      S_EMIT  = 8'b0100_0000,
      S_WAIT  = 8'b1000_0000
   } tsr_state_type;

   typedef enum logic [1:0] {
      ALU_ADD = 2'b01,
      ALU_SUB = 2'b10
   } tsr_alu_op_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic clr_en;
   } tsr_win_ctl_type;

   localparam int unsigned DROP_W = 16;
   localparam int unsigned POS_W  = 16;

endpackage

// File: rtl/tsr_alu.sv
// shared 32-bit add/subtract unit
module tsr_alu
   import tsr_pkg::*;
(
   input  tsr_alu_op_type op,
   input  logic [31:0]    operand_a,
   input  logic [31:0]    operand_b,
   output logic [31:0]    result
);

   always_comb begin
      case (op)
         ALU_ADD: result = operand_a + operand_b;
         ALU_SUB: result = operand_a - operand_b;
         default: result = operand_a;
      endcase
   end

endmodule

// File: rtl/tsr_window.sv
// circular window byte store with per-slot valid marks
module tsr_window
   import tsr_pkg::*;
#(
   parameter int unsigned WINDOW = 64,
   parameter int unsigned SLOT_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  tsr_win_ctl_type   ctl,
   input  logic [SLOT_W-1:0] wr_slot,
   input  logic [7:0]        wr_data,
   input  logic [SLOT_W-1:0] rd_slot,
   input  logic [SLOT_W-1:0] nxt_slot,
   output logic [7:0]        rd_data,
   output logic              rd_valid,
   output logic              nxt_valid
);

   logic [7:0]        mem [WINDOW];
   logic [7:0]        rd_data_ff;
   logic [WINDOW-1:0] valid_ff;
   logic [WINDOW-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_slot] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_slot];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clr_en) begin
         valid_in[rd_slot] = 1'b0;
      end
      if (ctl.wr_en) begin
         valid_in[wr_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data   = rd_data_ff;
   assign rd_valid  = valid_ff[rd_slot];
   assign nxt_valid = valid_ff[nxt_slot];

endmodule

// File: rtl/tcp_segment_reassembly_core.sv
// tcp segment reassembly core: sequencer, shared adder and window store
//
//   beat    | direction | handshake                 | payload
//   req_    | in        | req_valid / req_ready     | segment_seq, data_byte, segment_end
//   rsp_    | out       | rsp_valid / rsp_ready     | byte_valid, out_byte, run_last,
//           |           |                           | dropped_bytes
//   csr_    | in        | csr_write_enable          | csr_write_data (initial_sequence)
//
// each input byte is handled in order: accept, then three passes through the shared
// 32-bit adder (seq - initial, + position, - next expected) and a store step.
// at a segment end the drain steps through read, emit and wait for each result; wait holds on rsp_ready.
// reset is synchronous and clears all valid marks at once; no clearing pass.
// req_ready is low while a byte or a drain is in progress.
module tcp_segment_reassembly_core
   import tsr_pkg::*;
#(
   parameter int unsigned WINDOW = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_segment_seq,
   input  logic [7:0]  req_data_byte,
   input  logic        req_segment_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_byte_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic [15:0] rsp_dropped_bytes,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [SLOT_W:0] WIN_S = (SLOT_W+1)'(WINDOW);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

   tsr_state_type      state_ff, state_in;
   logic [31:0]        init_ff;
   logic [31:0]        seq_ff;
   logic [7:0]         byte_ff;
   logic               end_ff;
   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        next_ff, next_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [DROP_W-1:0]  drop_ff, drop_in;
   logic [SLOT_W-1:0]  base_ff, base_in;
   logic               out_bv_ff, out_bv_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;
   logic [DROP_W-1:0]  out_drop_ff, out_drop_in;

   tsr_alu_op_type     alu_op;
   logic [31:0]        alu_a;
   logic [31:0]        alu_b;
   logic [31:0]        alu_y;

   tsr_win_ctl_type    win_ctl;
   logic [SLOT_W:0]    slot_sum;
   logic [SLOT_W-1:0]  wr_slot;
   logic [SLOT_W-1:0]  nxt_slot;
   logic [7:0]         rd_data;
   logic               rd_valid;
   logic               nxt_valid;
   logic               in_window;

   tsr_alu u_alu (
      .op        (alu_op),
      .operand_a (alu_a),
      .operand_b (alu_b),
      .result    (alu_y)
   );

   tsr_window #(
      .WINDOW (WINDOW),
      .SLOT_W (SLOT_W)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .ctl       (win_ctl),
      .wr_slot   (wr_slot),
      .wr_data   (byte_ff),
      .rd_slot   (base_ff),
      .nxt_slot  (nxt_slot),
      .rd_data   (rd_data),
      .rd_valid  (rd_valid),
      .nxt_valid (nxt_valid)
   );

   assign slot_sum  = {1'b0, base_ff} + {1'b0, acc_ff[SLOT_W-1:0]};
   assign wr_slot   = (slot_sum >= WIN_S) ? SLOT_W'(slot_sum - WIN_S) : slot_sum[SLOT_W-1:0];
   assign nxt_slot  = (base_ff == LAST_SLOT) ? '0 : base_ff + SLOT_W'(1);
   assign in_window = acc_ff < 32'(WINDOW);

   always_comb begin
      alu_op = ALU_ADD;
      alu_a  = next_ff;
      alu_b  = 32'd1;
      case (state_ff)
         S_REL: begin
            alu_op = ALU_SUB;
            alu_a  = seq_ff;
            alu_b  = init_ff;
         end
         S_POS: begin
            alu_op = ALU_ADD;
            alu_a  = acc_ff;
            alu_b  = 32'(pos_ff);
         end
         S_OFF: begin
            alu_op = ALU_SUB;
            alu_a  = acc_ff;
            alu_b  = next_ff;
         end
         default: begin
            alu_op = ALU_ADD;
            alu_a  = next_ff;
            alu_b  = 32'd1;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      acc_in      = acc_ff;
      next_in     = next_ff;
      pos_in      = pos_ff;
      drop_in     = drop_ff;
      base_in     = base_ff;
      out_bv_in   = out_bv_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_drop_in = out_drop_ff;
      win_ctl     = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_REL;
            end
         end
         S_REL: begin
            acc_in   = alu_y;
            state_in = S_POS;
         end
         S_POS: begin
            acc_in   = alu_y;
            state_in = S_OFF;
         end
         S_OFF: begin
            acc_in   = alu_y;
            state_in = S_STORE;
         end
         S_STORE: begin
            if (in_window) begin
               win_ctl.wr_en = 1'b1;
            end else if (drop_ff != '1) begin
               drop_in = drop_ff + DROP_W'(1);
            end
            pos_in   = pos_ff + POS_W'(1);
            state_in = end_ff ? S_READ : S_IDLE;
         end
         S_READ: begin
            win_ctl.rd_en = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            out_drop_in = drop_ff;
            if (rd_valid) begin
               out_bv_in      = 1'b1;
               out_byte_in    = rd_data;
               out_last_in    = ~nxt_valid;
               win_ctl.clr_en = 1'b1;
               base_in        = nxt_slot;
               next_in        = alu_y;
            end else begin
               out_bv_in   = 1'b0;
               out_byte_in = '0;
               out_last_in = 1'b1;
            end
            if (~rd_valid | ~nxt_valid) begin
               pos_in  = '0;
               drop_in = '0;
            end
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (rsp_ready) begin
               state_in = out_last_ff ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         init_ff  <= '0;
         next_ff  <= '0;
         pos_ff   <= '0;
         drop_ff  <= '0;
         base_ff  <= '0;
      end else begin
         state_ff <= state_in;
         next_ff  <= next_in;
         pos_ff   <= pos_in;
         drop_ff  <= drop_in;
         base_ff  <= base_in;
         if (csr_write_enable) begin
            init_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         seq_ff  <= req_segment_seq;
         byte_ff <= req_data_byte;
         end_ff  <= req_segment_end;
      end
      acc_ff      <= acc_in;
      out_bv_ff   <= out_bv_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_drop_ff <= out_drop_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = (state_ff == S_WAIT);
   assign rsp_byte_valid    = out_bv_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_run_last      = out_last_ff;
   assign rsp_dropped_bytes = out_drop_ff;

endmodule

// File: tb/sv/tb_reasm_pkg.sv
// scoreboard and expected stream predictor for the tcp segment reassembly core
package tb_reasm_pkg;

   localparam int unsigned REASM_WINDOW = 64;

   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  out_byte;
      logic        run_last;
      logic [15:0] dropped_bytes;
   } stream_beat_t;

   class reasm_scoreboard;
      logic [31:0]  initial_sequence;
      logic [31:0]  stream_next;
      logic [15:0]  seg_position;
      logic [15:0]  seg_drops;
      logic [7:0]   window_bytes [REASM_WINDOW];
      bit           window_filled [REASM_WINDOW];
      stream_beat_t expected_stream [$];
      int           mismatches;

      function new();
         initial_sequence = '0;
         stream_next = '0;
         seg_position = '0;
         seg_drops = '0;
         mismatches = 0;
         foreach (window_bytes[i]) begin
            window_bytes[i] = '0;
            window_filled[i] = 1'b0;
         end
      endfunction

      function int pending();
         return expected_stream.size();
      endfunction

      function void note_segment_byte(logic [31:0] seq, logic [7:0] data, logic seg_end);
         logic [31:0]  offset;
         int           run;
         stream_beat_t beat;
         offset = seq - initial_sequence + {16'd0, seg_position} - stream_next;
         if (offset < REASM_WINDOW) begin
            window_bytes[int'(offset)] = data;
            window_filled[int'(offset)] = 1'b1;
         end else if (seg_drops != 16'hFFFF) begin
            seg_drops = seg_drops + 16'd1;
         end
         seg_position = seg_position + 16'd1;
         if (!seg_end)
            return;
         run = 0;
         while (run < REASM_WINDOW && window_filled[run])
            run++;
         if (run == 0) begin
            beat = '{byte_valid: 1'b0, out_byte: 8'h00, run_last: 1'b1,
                     dropped_bytes: seg_drops};
            expected_stream.push_back(beat);
         end else begin
            for (int i = 0; i < run; i++) begin
               beat = '{byte_valid: 1'b1, out_byte: window_bytes[i],
                        run_last: (i == run - 1), dropped_bytes: seg_drops};
               expected_stream.push_back(beat);
            end
            stream_next = stream_next + run;
            for (int i = 0; i < REASM_WINDOW; i++) begin
               if (i + run < REASM_WINDOW) begin
                  window_bytes[i] = window_bytes[i + run];
                  window_filled[i] = window_filled[i + run];
               end else begin
                  window_bytes[i] = '0;
                  window_filled[i] = 1'b0;
               end
            end
         end
         seg_position = '0;
         seg_drops = '0;
      endfunction

      function void check_beat(stream_beat_t got);
         stream_beat_t want;
         if (expected_stream.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp beat: byte_valid=%0b out_byte=%02h run_last=%0b dropped=%0d",
                        got.byte_valid, got.out_byte, got.run_last, got.dropped_bytes);
            return;
         end
         want = expected_stream.pop_front();
         if (got.byte_valid !== want.byte_valid || got.out_byte !== want.out_byte ||
             got.run_last !== want.run_last || got.dropped_bytes !== want.dropped_bytes) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rsp mismatch: exp byte_valid=%0b out_byte=%02h run_last=%0b dropped=%0d, got byte_valid=%0b out_byte=%02h run_last=%0b dropped=%0d",
                        want.byte_valid, want.out_byte, want.run_last, want.dropped_bytes,
                        got.byte_valid, got.out_byte, got.run_last, got.dropped_bytes);
         end
      endfunction
   endclass

endpackage

// File: tb/sv/tb.sv
// testbench top for the tcp segment reassembly core
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tb_reasm_pkg::*;

   localparam int SETTLE_CYCLES = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_segment_seq = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_segment_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_byte_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic [15:0] rsp_dropped_bytes;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;

   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        hold_go = 1'b0;
   int          hold_len = 0;
   int          hold_left = 0;

   reasm_scoreboard sb;
   stream_beat_t    seen;

   tcp_segment_reassembly_core #(
      .WINDOW(REASM_WINDOW)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_segment_seq  (req_segment_seq),
      .req_data_byte    (req_data_byte),
      .req_segment_end  (req_segment_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_dropped_bytes(rsp_dropped_bytes),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, plus a long counted hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_go) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_len;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{byte_valid: rsp_byte_valid, out_byte: rsp_out_byte,
                  run_last: rsp_run_last, dropped_bytes: rsp_dropped_bytes};
         sb.check_beat(seen);
      end
   end

   task automatic write_initial_sequence(input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.initial_sequence = value;
   endtask

   task automatic send_byte(input logic [31:0] seq, input logic [7:0] data, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_segment_seq <= seq;
      req_data_byte <= data;
      req_segment_end <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_segment_byte(seq, data, last);
   endtask

   task automatic send_segment(input logic [31:0] seq, input int len);
      for (int i = 0; i < len; i++)
         send_byte(seq, 8'($urandom_range(255)), i == len - 1);
   endtask

   task automatic drain_phase();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_directed();
      logic [31:0] base;
      base = sb.initial_sequence;
      // window edge: one past the end, then the last slot
      send_byte(base + 32'd64, 8'h00, 1'b1);
      send_byte(base + 32'd63, 8'hFF, 1'b1);
      // stale byte, then overwrite of a held byte
      send_byte(base - 32'd1, 8'hFF, 1'b1);
      send_byte(base + 32'd2, 8'h00, 1'b1);
      send_byte(base + 32'd2, 8'h5A, 1'b1);
      // gap fill releases a run
      send_byte(base, 8'hFF, 1'b0);
      send_byte(base, 8'h00, 1'b1);
      // retransmit partly behind the stream
      send_segment(base + 32'd1, 4);
      send_byte(32'h0000_0000, 8'hFF, 1'b1);
      send_byte(32'hFFFF_FFFF, 8'h00, 1'b1);
      // segment running past the window end
      send_segment(base + sb.stream_next + 32'd60, 6);
   endtask

   task automatic run_random(input int count);
      int          sent;
      int          kind;
      int          len;
      logic [31:0] base;
      sent = 0;
      while (sent < count) begin
         base = sb.initial_sequence + sb.stream_next;
         kind = $urandom_range(99);
         if (kind < 40) begin
            len = $urandom_range(1, 6);
            send_segment(base, len);
         end else if (kind < 65) begin
            len = $urandom_range(1, 8);
            send_segment(base + 32'($urandom_range(1, 70)), len);
         end else if (kind < 78) begin
            len = $urandom_range(2, 12);
            send_segment(base - 32'($urandom_range(1, 8)), len);
         end else if (kind < 90) begin
            len = $urandom_range(1, 4);
            send_segment($urandom(), len);
         end else begin
            len = $urandom_range(1, 3);
            send_segment(base - 32'($urandom_range(64, 32'h7FFF_FFFF)), len);
         end
         sent += len;
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_initial_sequence(32'hFFFF_FFFE);
      run_directed();
      drain_phase();

      write_initial_sequence(32'h0000_0000);
      send_idle_pct = 82;
      run_random(80);
      drain_phase();

      write_initial_sequence(32'hFFFF_FFFF);
      send_idle_pct = 0;
      recv_stall_pct = 82;
      run_random(80);
      drain_phase();

      write_initial_sequence($urandom());
      send_idle_pct = 24;
      recv_stall_pct = 24;
      run_random(80);
      drain_phase();

      // long receiver hold-off while the sender keeps pushing
      write_initial_sequence($urandom());
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_len <= 400;
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      run_random(80);
      drain_phase();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("tb: FAIL");
      $finish;
   end

endmodule
